// File: hw/rtl/pdrk_pkg.sv
// ----------------------------------------------------------------------------
// pdrk_pkg : shared types and constants of the pd-controlled rk4 plant step
// Word formats, fixed-point settings, register indexes, sequencer codes and
// the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pdrk_pkg;

    // fixed-point settings
    localparam int WORD_W    = 32;
    localparam int DT_SHIFT  = 10;
    localparam int FRAC_BITS = 16;

    // derived widths
    localparam int ACC_W         = WORD_W + 2;     // sum of three words
    localparam int SUM_W         = WORD_W + 4;     // k1 + 2*k2 + 2*k3 + k4
    localparam int QUOT_W        = SUM_W + 2;      // biased dividend / quotient
    localparam int QUOT_BIAS_EXP = SUM_W - 2;      // quotient bias is 2^this
    localparam int SAT_W         = 2 * WORD_W + 2; // widest value to clamp

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [QUOT_W-1:0] t_quot;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(WORD_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(WORD_MIN);

    // configuration registers
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_POS_FROM_POS = 3'd0;
    localparam t_cfg_idx REG_POS_FROM_VEL = 3'd1;
    localparam t_cfg_idx REG_VEL_FROM_POS = 3'd2;
    localparam t_cfg_idx REG_VEL_FROM_VEL = 3'd3;
    localparam t_cfg_idx REG_DRIVE_TO_POS = 3'd4;
    localparam t_cfg_idx REG_DRIVE_TO_VEL = 3'd5;
    localparam t_cfg_idx REG_PROP_GAIN    = 3'd6;
    localparam t_cfg_idx REG_DERIV_GAIN   = 3'd7;

    localparam t_word CFG_RESET [NUM_REGS] = '{
        32'sd0, 32'sd65536, -32'sd655360, -32'sd65536,
        32'sd65536, 32'sd65536, 32'sd327680, 32'sd65536
    };

    // product sequence: four setup products, then four per rk stage
    typedef logic [4:0] t_op;
    localparam t_op OP_KP  = 5'd0;
    localparam t_op OP_KD  = 5'd1;
    localparam t_op OP_BU0 = 5'd2;
    localparam t_op OP_BU1 = 5'd3;
    localparam t_op OP_RK  = 5'd4;

    // product within an rk stage, low bits of the op counter
    typedef logic [1:0] t_lane;
    localparam t_lane LANE_PP = 2'd0;
    localparam t_lane LANE_PV = 2'd1;
    localparam t_lane LANE_VP = 2'd2;
    localparam t_lane LANE_VV = 2'd3;

    typedef logic [1:0] t_stage;
    localparam t_stage STG_K1 = 2'd0;
    localparam t_stage STG_K2 = 2'd1;
    localparam t_stage STG_K3 = 2'd2;
    localparam t_stage STG_K4 = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ERR,
        S_MSTART,
        S_MWAIT,
        S_STAGE,
        S_ADV,
        S_DIVP,
        S_DWAITP,
        S_DIVV,
        S_DWAITV,
        S_DONE
    } t_state;

    // clamp to the signed 32-bit range
    function automatic t_word f_sat(input logic signed [SAT_W-1:0] v);
        t_word res;
        if (v > SAT_MAX) begin
            res = WORD_MAX;
        end else if (v < SAT_MIN) begin
            res = WORD_MIN;
        end else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/pdrk_in_if.sv
// ----------------------------------------------------------------------------
// pdrk_in_if : request channel carrying one target position
// Valid/ready handshake with a signed q16.16 target.
// ----------------------------------------------------------------------------
interface pdrk_in_if;
    import pdrk_pkg::*;

    logic  valid;
    logic  ready;
    t_word target;

    modport source (output valid, output target, input ready);
    modport sink   (input valid, input target, output ready);
endinterface

// File: hw/rtl/pdrk_out_if.sv
// ----------------------------------------------------------------------------
// pdrk_out_if : result channel carrying the new plant state and the drive
// Valid/ready handshake with three signed q16.16 words.
// ----------------------------------------------------------------------------
interface pdrk_out_if;
    import pdrk_pkg::*;

    logic  valid;
    logic  ready;
    t_word position;
    t_word velocity;
    t_word drive;

    modport source (output valid, output position, output velocity, output drive,
                    input ready);
    modport sink   (input valid, input position, input velocity, input drive,
                    output ready);
endinterface

// File: hw/rtl/pdrk_mul.sv
// ----------------------------------------------------------------------------
// pdrk_mul : bit-serial signed fixed-point multiplier
// One multiplier bit per cycle, round half up to FRAC_BITS, saturate to 32 bits.
// ----------------------------------------------------------------------------
module pdrk_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pdrk_pkg::t_word i_a,
    input  pdrk_pkg::t_word i_b,
    output logic          o_done,
    output pdrk_pkg::t_word o_prod
);
    import pdrk_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic signed [WORD_W:0] RND_INIT = (WORD_W + 1)'(1) <<< (FRAC_BITS - 1);

    logic                      r_run;
    logic                      r_fin;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    t_word                     r_a;
    logic signed [WORD_W:0]    r_h;
    logic [WORD_W-1:0]         r_l;
    t_word                     r_prod;

    logic                      w_last;
    logic signed [WORD_W+1:0]  w_a_ext;
    logic signed [WORD_W+1:0]  w_add;
    logic signed [WORD_W+1:0]  w_t;
    logic signed [2*WORD_W:0]  w_prod;
    logic signed [SAT_W-1:0]   w_scaled;

    assign w_last  = (r_cnt == CNT_W'(WORD_W - 1));
    assign w_a_ext = (WORD_W + 2)'(r_a);

    // sign bit of the multiplier carries negative weight
    always_comb begin
        if (r_l[0]) begin
            w_add = w_last ? -w_a_ext : w_a_ext;
        end else begin
            w_add = '0;
        end
    end

    assign w_t      = (WORD_W + 2)'(r_h) + w_add;
    assign w_prod   = {r_h, r_l};
    assign w_scaled = SAT_W'(w_prod) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_l <= i_b;
            r_h <= RND_INIT;
        end else if (r_run) begin
            r_h <= w_t[WORD_W+1:1];
            r_l <= {w_t[0], r_l[WORD_W-1:1]};
        end
        if (r_fin) begin
            r_prod <= f_sat(w_scaled);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// File: hw/rtl/pdrk_div6.sv
// ----------------------------------------------------------------------------
// pdrk_div6 : bit-serial rk4 weight divider
// Rounded floor of sum / (6 * 2^DT_SHIFT), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdrk_div6 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pdrk_pkg::t_sum  i_sum,
    output logic           o_done,
    output pdrk_pkg::t_quot o_quot
);
    import pdrk_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam int EXT_W = QUOT_W + DT_SHIFT;
    localparam int TOP_W = QUOT_W - QUOT_BIAS_EXP;
    // half-divisor rounding plus a multiple of six that keeps the dividend positive
    localparam logic [EXT_W-1:0] OFFSET =
        (EXT_W'(3) << DT_SHIFT) + (EXT_W'(6) << (QUOT_BIAS_EXP + DT_SHIFT));
    localparam logic [3:0] DIVISOR = 4'd6;

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [QUOT_W-1:0] r_m;
    logic [2:0]        r_rem;

    logic [EXT_W-1:0]  w_ext;
    logic [3:0]        w_x;
    logic              w_ge;
    logic [2:0]        n_rem;
    logic              w_last;

    assign w_ext  = EXT_W'(i_sum) + OFFSET;
    assign w_x    = {r_rem, r_m[QUOT_W-1]};
    assign w_ge   = (w_x >= DIVISOR);
    assign n_rem  = w_ge ? 3'(w_x - DIVISOR) : w_x[2:0];
    assign w_last = (r_cnt == CNT_W'(QUOT_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= w_ext[EXT_W-1:DT_SHIFT];
            r_rem <= '0;
        end else if (r_run) begin
            r_m   <= {r_m[QUOT_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    // remove the quotient bias
    assign o_quot = {r_m[QUOT_W-1:QUOT_BIAS_EXP] - TOP_W'(1), r_m[QUOT_BIAS_EXP-1:0]};
    assign o_done = r_done;

endmodule

// File: hw/rtl/pd_controlled_plant_rk4_step.sv
// ----------------------------------------------------------------------------
// pd_controlled_plant_rk4_step : pd-controlled two-state plant, one rk4 step
// Each request carries a target position; the block forms the pd drive and
// advances (position, velocity) by one fourth-order runge-kutta step.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake     payload (signed q16.16)
//  i_req     in   valid/ready   target
//  o_res     out  valid/ready   position, velocity, drive
//  cfg       in   i_cfg_we      i_cfg_idx, i_cfg_data (no read-back)
//
//  one request is handled in full before the next one can be taken: twenty
//  products through the shared bit-serial multiplier, two bit-serial
//  divisions by six, and the adds and sequencing.
//  reset (synchronous, active low) clears the plant state, the last target and
//  the output valid, and loads the register defaults.
//  a finished result sits in the output register; the next request is taken
//  meanwhile and only its own completion waits for that register to drain.
//
module pd_controlled_plant_rk4_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  pdrk_pkg::t_cfg_idx i_cfg_idx,
    input  pdrk_pkg::t_word    i_cfg_data,
    pdrk_in_if.sink           i_req,
    pdrk_out_if.source        o_res
);
    import pdrk_pkg::*;

    localparam logic signed [WORD_W:0] RND_HALF_DT = (WORD_W + 1)'(1) <<< DT_SHIFT;
    localparam logic signed [WORD_W:0] RND_FULL_DT = (WORD_W + 1)'(1) <<< (DT_SHIFT - 1);

    // sequencer
    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_stage r_stage;

    // configuration and plant state
    t_word  r_cfg [NUM_REGS];
    t_word  r_p;
    t_word  r_v;
    t_word  r_lt;

    // working registers
    t_word  r_r;      // target of the current request
    t_word  r_e1;     // position error
    t_word  r_e2;     // target rate, then velocity error
    t_word  r_u;      // drive
    t_word  r_bu0;
    t_word  r_bu1;
    t_word  r_ps;     // stage input position
    t_word  r_vs;     // stage input velocity
    t_word  r_kp;
    t_word  r_kv;
    t_word  r_dp;     // scaled stage increments
    t_word  r_dv;
    t_acc   r_acc;
    t_sum   r_sp;
    t_sum   r_sv;

    // output register
    logic   r_ov;
    t_word  r_o_pos;
    t_word  r_o_vel;
    t_word  r_o_drv;

    logic   w_mul_start;
    logic   w_mul_done;
    t_word  w_mul_a;
    t_word  w_mul_b;
    t_word  w_mul_prod;
    logic   w_div_start;
    logic   w_div_done;
    t_sum   w_div_sum;
    t_quot  w_div_quot;

    t_acc   w_acc_sum;
    logic   w_out_free;
    logic   w_rk_op;
    logic   w_double;
    logic   w_full_dt;

    // rounded k * dt / 2 or k * dt
    function automatic t_word f_stage_inc(input t_word k, input logic full_dt);
        logic signed [WORD_W:0] ext;
        logic signed [WORD_W:0] res;
        ext = (WORD_W + 1)'(k);
        if (full_dt) begin
            res = (ext + RND_FULL_DT) >>> DT_SHIFT;
        end else begin
            res = (ext + RND_HALF_DT) >>> (DT_SHIFT + 1);
        end
        return WORD_W'(res);
    endfunction

    assign w_out_free = !r_ov || o_res.ready;
    assign w_rk_op    = (r_op >= OP_RK);
    assign w_acc_sum  = r_acc + ACC_W'(w_mul_prod);
    // k2 and k3 count twice in the update
    assign w_double   = (r_stage == STG_K2) || (r_stage == STG_K3);
    // the k4 stage input uses a full step
    assign w_full_dt  = (r_stage == STG_K3);

    pdrk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    pdrk_div6 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_div_sum),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_PREP;
            end
            S_PREP:   n_state = S_ERR;
            S_ERR:    n_state = S_MSTART;
            S_MSTART: n_state = S_MWAIT;
            S_MWAIT: begin
                if (w_mul_done) begin
                    // the last product of a stage closes the velocity slope
                    if (w_rk_op && (t_lane'(r_op[1:0]) == LANE_VV)) begin
                        n_state = S_STAGE;
                    end else begin
                        n_state = S_MSTART;
                    end
                end
            end
            S_STAGE: begin
                n_state = (r_stage == STG_K4) ? S_DIVP : S_ADV;
            end
            S_ADV:    n_state = S_MSTART;
            S_DIVP:   n_state = S_DWAITP;
            S_DWAITP: begin
                if (w_div_done) n_state = S_DIVV;
            end
            S_DIVV:   n_state = S_DWAITV;
            S_DWAITV: begin
                if (w_div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs and operand selection
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_mul_start = (r_state == S_MSTART);
        w_div_start = (r_state == S_DIVP) || (r_state == S_DIVV);
        w_div_sum   = (r_state == S_DIVV) ? r_sv : r_sp;

        case (r_op)
            OP_KP: begin
                w_mul_a = r_cfg[REG_PROP_GAIN];
                w_mul_b = r_e1;
            end
            OP_KD: begin
                w_mul_a = r_cfg[REG_DERIV_GAIN];
                w_mul_b = r_e2;
            end
            OP_BU0: begin
                w_mul_a = r_cfg[REG_DRIVE_TO_POS];
                w_mul_b = r_u;
            end
            OP_BU1: begin
                w_mul_a = r_cfg[REG_DRIVE_TO_VEL];
                w_mul_b = r_u;
            end
            default: begin
                case (t_lane'(r_op[1:0]))
                    LANE_PP: begin
                        w_mul_a = r_cfg[REG_POS_FROM_POS];
                        w_mul_b = r_ps;
                    end
                    LANE_PV: begin
                        w_mul_a = r_cfg[REG_POS_FROM_VEL];
                        w_mul_b = r_vs;
                    end
                    LANE_VP: begin
                        w_mul_a = r_cfg[REG_VEL_FROM_POS];
                        w_mul_b = r_ps;
                    end
                    default: begin
                        w_mul_a = r_cfg[REG_VEL_FROM_VEL];
                        w_mul_b = r_vs;
                    end
                endcase
            end
        endcase
    end

    // control, configuration and plant state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_KP;
            r_stage <= STG_K1;
            r_ov    <= 1'b0;
            r_p     <= '0;
            r_v     <= '0;
            r_lt    <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_ERR: begin
                    r_op    <= OP_KP;
                    r_stage <= STG_K1;
                end
                S_MWAIT: begin
                    if (w_mul_done) r_op <= r_op + t_op'(1);
                end
                S_ADV: begin
                    r_stage <= r_stage + t_stage'(1);
                end
                S_DWAITP: begin
                    if (w_div_done) r_p <= f_sat(SAT_W'(r_p) + SAT_W'(w_div_quot));
                end
                S_DWAITV: begin
                    if (w_div_done) r_v <= f_sat(SAT_W'(r_v) + SAT_W'(w_div_quot));
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ov <= 1'b1;
                        r_lt <= r_r;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) r_r <= i_req.target;
            end
            S_PREP: begin
                r_e1 <= f_sat(SAT_W'(r_r) - SAT_W'(r_p));
                // target rate: difference scaled by 1/dt
                r_e2 <= f_sat((SAT_W'(r_r) - SAT_W'(r_lt)) <<< DT_SHIFT);
            end
            S_ERR: begin
                r_e2  <= f_sat(SAT_W'(r_e2) - SAT_W'(r_v));
                r_acc <= '0;
                r_sp  <= '0;
                r_sv  <= '0;
            end
            S_MWAIT: begin
                if (w_mul_done) begin
                    case (r_op)
                        OP_KP:  r_acc <= w_acc_sum;
                        OP_KD:  r_u   <= f_sat(SAT_W'(w_acc_sum));
                        OP_BU0: r_bu0 <= w_mul_prod;
                        OP_BU1: begin
                            r_bu1 <= w_mul_prod;
                            // first stage starts at the current state
                            r_acc <= ACC_W'(r_bu0);
                            r_ps  <= r_p;
                            r_vs  <= r_v;
                        end
                        default: begin
                            case (t_lane'(r_op[1:0]))
                                LANE_PV: begin
                                    r_kp  <= f_sat(SAT_W'(w_acc_sum));
                                    r_acc <= ACC_W'(r_bu1);
                                end
                                LANE_VV: r_kv  <= f_sat(SAT_W'(w_acc_sum));
                                default: r_acc <= w_acc_sum;
                            endcase
                        end
                    endcase
                end
            end
            S_STAGE: begin
                if (w_double) begin
                    r_sp <= r_sp + (SUM_W'(r_kp) <<< 1);
                    r_sv <= r_sv + (SUM_W'(r_kv) <<< 1);
                end else begin
                    r_sp <= r_sp + SUM_W'(r_kp);
                    r_sv <= r_sv + SUM_W'(r_kv);
                end
                r_dp <= f_stage_inc(r_kp, w_full_dt);
                r_dv <= f_stage_inc(r_kv, w_full_dt);
            end
            S_ADV: begin
                r_ps  <= f_sat(SAT_W'(r_p) + SAT_W'(r_dp));
                r_vs  <= f_sat(SAT_W'(r_v) + SAT_W'(r_dv));
                r_acc <= ACC_W'(r_bu0);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_o_pos <= r_p;
                    r_o_vel <= r_v;
                    r_o_drv <= r_u;
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid    = r_ov;
    assign o_res.position = r_o_pos;
    assign o_res.velocity = r_o_vel;
    assign o_res.drive    = r_o_drv;

endmodule

// File: sim/pdrk_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrk_step_checker : result predictor and scoreboard for the rk4 plant step
// Watches register writes, requests and results. Each accepted request is run
// through a 64-bit integer copy of the fixed-point datapath. The predicted
// position, velocity and drive are queued and compared with each result.
// ----------------------------------------------------------------------------
module pdrk_step_checker
    import pdrk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_word    i_cfg_data,
    pdrk_in_if       i_req,
    pdrk_out_if      i_res,
    output int       o_pending,
    output int       o_errors
);

    typedef struct packed {
        t_word position;
        t_word velocity;
        t_word drive;
    } plant_out_t;

    localparam t_word COEF_DEFAULT [NUM_REGS] = '{
        32'sd0, 32'sd65536, -32'sd655360, -32'sd65536,
        32'sd65536, 32'sd65536, 32'sd327680, 32'sd65536
    };

    t_word      coef [NUM_REGS];
    t_word      pos_now;
    t_word      vel_now;
    t_word      prev_target;
    plant_out_t awaited_steps [$];
    int         fail_count = 0;

    function automatic t_word clamp32(input longint v);
        if (v > longint'(WORD_MAX)) return WORD_MAX;
        if (v < longint'(WORD_MIN)) return WORD_MIN;
        return t_word'(v);
    endfunction

    function automatic longint floor_div(input longint num, input longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // round half up, then drop s bits
    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic t_word qmul(input t_word a, input t_word b);
        return clamp32(round_shr(longint'(a) * longint'(b), FRAC_BITS));
    endfunction

    // state plus a scaled slope, used for the stage inputs
    function automatic t_word nudge(input t_word x, input t_word k, input int s);
        return clamp32(longint'(x) + round_shr(longint'(k), s));
    endfunction

    function automatic void slope(input t_word p, input t_word v, input t_word bu_p,
                                  input t_word bu_v, output t_word dp, output t_word dv);
        dp = clamp32(longint'(qmul(coef[REG_POS_FROM_POS], p))
                     + longint'(qmul(coef[REG_POS_FROM_VEL], v)) + longint'(bu_p));
        dv = clamp32(longint'(qmul(coef[REG_VEL_FROM_POS], p))
                     + longint'(qmul(coef[REG_VEL_FROM_VEL], v)) + longint'(bu_v));
    endfunction

    function automatic plant_out_t advance_plant(input t_word tgt);
        t_word      rate, drv, bu_p, bu_v;
        t_word      k1p, k1v, k2p, k2v, k3p, k3v, k4p, k4v;
        longint     sum_p, sum_v, den;
        plant_out_t res;
        rate = clamp32((longint'(tgt) - longint'(prev_target)) * (longint'(1) << DT_SHIFT));
        drv  = clamp32(
            longint'(qmul(coef[REG_PROP_GAIN], clamp32(longint'(tgt) - longint'(pos_now))))
            + longint'(qmul(coef[REG_DERIV_GAIN],
                            clamp32(longint'(rate) - longint'(vel_now)))));
        bu_p = qmul(coef[REG_DRIVE_TO_POS], drv);
        bu_v = qmul(coef[REG_DRIVE_TO_VEL], drv);
        slope(pos_now, vel_now, bu_p, bu_v, k1p, k1v);
        slope(nudge(pos_now, k1p, DT_SHIFT + 1), nudge(vel_now, k1v, DT_SHIFT + 1),
              bu_p, bu_v, k2p, k2v);
        slope(nudge(pos_now, k2p, DT_SHIFT + 1), nudge(vel_now, k2v, DT_SHIFT + 1),
              bu_p, bu_v, k3p, k3v);
        slope(nudge(pos_now, k3p, DT_SHIFT), nudge(vel_now, k3v, DT_SHIFT),
              bu_p, bu_v, k4p, k4v);
        // weighted slope sums are kept exact
        sum_p = longint'(k1p) + 2 * longint'(k2p) + 2 * longint'(k3p) + longint'(k4p);
        sum_v = longint'(k1v) + 2 * longint'(k2v) + 2 * longint'(k3v) + longint'(k4v);
        den   = longint'(6) << DT_SHIFT;
        res.position = clamp32(longint'(pos_now) + floor_div(sum_p + den / 2, den));
        res.velocity = clamp32(longint'(vel_now) + floor_div(sum_v + den / 2, den));
        res.drive    = drv;
        pos_now     = res.position;
        vel_now     = res.velocity;
        prev_target = tgt;
        return res;
    endfunction

    function automatic void check_field(input string name, input t_word want, input t_word got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        plant_out_t want;
        if (!i_rst_n) begin
            coef        = COEF_DEFAULT;
            pos_now     = '0;
            vel_now     = '0;
            prev_target = '0;
            awaited_steps.delete();
        end else begin
            if (i_cfg_we) begin
                coef[i_cfg_idx] = i_cfg_data;
            end
            if (i_res.valid && i_res.ready) begin
                if (awaited_steps.size() == 0) begin
                    fail_count++;
                    $error("unexpected result: position %0d velocity %0d drive %0d",
                           i_res.position, i_res.velocity, i_res.drive);
                end else begin
                    want = awaited_steps.pop_front();
                    check_field("position", want.position, i_res.position);
                    check_field("velocity", want.velocity, i_res.velocity);
                    check_field("drive", want.drive, i_res.drive);
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_steps.push_back(advance_plant(i_req.target));
            end
        end
        o_pending <= awaited_steps.size();
        o_errors  <= fail_count;
    end

endmodule

// File: sim/pd_controlled_plant_rk4_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_controlled_plant_rk4_step_test : testbench top of the rk4 plant step
// Drives target requests and register writes, stalls both channels in random
// bursts and leaves prediction and comparison to the step checker.
// ----------------------------------------------------------------------------
module pd_controlled_plant_rk4_step_test;
    import pdrk_pkg::*;

    // the cycle limit leaves room for about 1500 requests even when every one
    // of them also sees the longest sender gap and the longest result stall,
    // and it is several times what such a worst case needs
    localparam int CYCLE_LIMIT  = 20_000_000;
    // cycles to watch for stray results once everything has arrived
    localparam int DRAIN_CYCLES = 800;
    localparam int PHASE_ITEMS  = 150;

    // how a phase loads the coefficient registers
    typedef enum int {
        CFG_KEEP,
        CFG_MILD,
        CFG_ALL_MAX,
        CFG_ALL_MIN,
        CFG_ZERO,
        CFG_ALTERNATE,
        CFG_WILD,
        CFG_DEFAULTS
    } cfg_mode_t;

    localparam cfg_mode_t PHASE_PLAN [10] = '{
        CFG_KEEP, CFG_MILD, CFG_ALL_MAX, CFG_MILD, CFG_ALL_MIN,
        CFG_ZERO, CFG_ALTERNATE, CFG_WILD, CFG_WILD, CFG_DEFAULTS
    };

    // opening sequence: the first step after reset sees the full target as
    // its rate, then a flat target, the rail values in both orders so that
    // the rate saturates both ways, single-lsb and alternating-bit words
    localparam t_word OPENING [19] = '{
        32'sh0001_0000, 32'sh0001_0000, 32'sd0, -32'sd65536,
        WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 32'sd0,
        32'sd1, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
        32'sh0000_8000, 32'shFFFF_8000, 32'sd0, 32'sd0, 32'sd0
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_word    i_cfg_data;
    logic     quiet = 1'b0;
    int       pending;
    int       errors;
    int       cycles;

    pdrk_in_if  req_ch ();
    pdrk_out_if res_ch ();

    pd_controlled_plant_rk4_step u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    pdrk_step_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // value of one coefficient register for a phase
    function automatic t_word coef_value(input cfg_mode_t mode, input int idx);
        case (mode)
            CFG_MILD:      return t_word'($urandom_range(0, 524288)) - 32'sd262144;
            CFG_ALL_MAX:   return WORD_MAX;
            CFG_ALL_MIN:   return WORD_MIN;
            CFG_ZERO:      return '0;
            CFG_ALTERNATE: return idx[0] ? WORD_MIN : WORD_MAX;
            CFG_WILD:      return t_word'($urandom());
            default:       return CFG_RESET[idx];
        endcase
    endfunction

    // half the time a smooth trajectory around the previous target, otherwise
    // jumps, rail values and fully random words
    function automatic t_word pick_target(input t_word prev);
        case ($urandom_range(0, 9))
            0, 1:    return t_word'($urandom());
            2:       return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            3, 4:    return t_word'($urandom_range(0, 2097152)) - 32'sd1048576;
            default: return prev + t_word'($urandom_range(0, 8192)) - 32'sd4096;
        endcase
    endfunction

    // present one request and hold it until the block takes it
    task automatic push_target(input t_word tgt);
        req_ch.valid  <= 1'b1;
        req_ch.target <= tgt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // optional gap after a request; now and then several bursts back to
    // back so that the next request lands late in the block's work
    task automatic idle_sender();
        int span;
        if (quiet || $urandom_range(0, 3) != 0) return;
        span = $urandom_range(1, 14);
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 50)) span += $urandom_range(1, 14);
        end
        req_ch.valid  <= 1'b0;
        req_ch.target <= t_word'($urandom());
        repeat (span) @(posedge i_clk);
    endtask

    // stop requesting and wait until every predicted result has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_coef(input t_cfg_idx idx, input t_word val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_coefs(input cfg_mode_t mode);
        for (int r = 0; r < NUM_REGS; r++) begin
            write_coef(t_cfg_idx'(r), coef_value(mode, r));
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        t_word tgt;
        req_ch.valid  <= 1'b0;
        req_ch.target <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening on the reset coefficients
        foreach (OPENING[d]) begin
            push_target(OPENING[d]);
            idle_sender();
        end
        tgt = OPENING[$size(OPENING) - 1];

        // random phases, each but the first loading its own register setting while idle
        for (int ph = 0; ph < $size(PHASE_PLAN); ph++) begin
            settle();
            if (PHASE_PLAN[ph] != CFG_KEEP) begin
                load_coefs(PHASE_PLAN[ph]);
            end
            // the last phase runs at full rate on both sides
            if (ph == $size(PHASE_PLAN) - 1) begin
                quiet = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                tgt = pick_target(tgt);
                push_target(tgt);
                idle_sender();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // result side: ready in random patterns, with long stalls that keep
    // a finished result waiting while the next request is being worked on
    initial begin : result_drain
        int span;
        res_ch.ready <= 1'b0;
        forever begin
            if (quiet || $urandom_range(0, 9) == 0) begin
                res_ch.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(100, 1500)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                span = $urandom_range(1, 14);
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 60)) span += $urandom_range(1, 14);
                end
                res_ch.ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
